@@ design/cqsr_pkg.sv @@
package cqsr_pkg;

	// Default sizes of the slot store.
	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	// Fixed field widths.
	localparam int CMD_BITS    = 2;
	localparam int STATUS_BITS = 2;
	localparam int POS_BITS    = 5;
	localparam int APB_DATA    = 32;
	localparam int APB_ADDR    = 3;

	// Register indexes.
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_FIND = 2'd2,
		CMD_REPL = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEQ,
		ST_SCAN,
		ST_FIN
	} state_t;

	// Capacity write request from the register port.
	typedef struct packed {
		logic                we;
		logic [APB_DATA-1:0] wdata;
	} cfg_wr_t;

endpackage

@@ design/circular_queue_search_replace.sv @@
// Circular queue of signed words with a programmable capacity, stored in a
// single-port-read slot memory. Each command item yields exactly one result
// item. Search and replace scan the occupied slots, one slot per cycle
// through the memory's read port, front to back, and stop at the first
// match. A new result item is only loaded once the output register is
// free, and no new command item is taken until the result item of the
// last one has been loaded. A replace writes the new word into the
// matching slot as soon as it is found. The capacity register sits at byte
// address 0; it is taken only while the queue is empty, resets the front and
// back pointers, and saturates zero to one and values above the storage
// depth to the depth. Slot contents are not cleared at reset, and only
// occupied slots are ever read.
module circular_queue_search_replace
	import cqsr_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Command channel.
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [CMD_BITS-1:0]         cmd,
	input  logic signed [WORD_BITS-1:0] value,
	input  logic signed [WORD_BITS-1:0] new_value,
	// Result channel.
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [STATUS_BITS-1:0]      status,
	output logic signed [WORD_BITS-1:0] data,
	output logic [POS_BITS-1:0]         position,
	// Register port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [APB_ADDR-1:0]         paddr,
	input  logic [APB_DATA-1:0]         pwdata,
	output logic [APB_DATA-1:0]         prdata,
	output logic                        pready
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cfg_wr_t              cfg;
	logic [CNT_W-1:0]     capacity;
	logic                 ram_we, ram_re;
	logic [IDX_W-1:0]     ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
	logic [WORD_BITS-1:0] data_u;

	// The port never stalls; a write lands on the access cycle.
	assign pready    = 1'b1;
	assign cfg.we    = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
	assign cfg.wdata = pwdata;
	assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DATA'(capacity) : '0;

	cqsr_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.value     (value),
		.new_value (new_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data      (data_u),
		.position  (position),
		.cfg       (cfg),
		.capacity  (capacity),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	assign data = data_u;

	cqsr_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ design/cqsr_ram.sv @@
module cqsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/cqsr_ctrl.sv @@
module cqsr_ctrl
	import cqsr_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Command channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_BITS-1:0]  cmd,
	input  logic [WORD_BITS-1:0] value,
	input  logic [WORD_BITS-1:0] new_value,
	// Result channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_BITS-1:0] status,
	output logic [WORD_BITS-1:0] data,
	output logic [POS_BITS-1:0]  position,
	// Configuration.
	input  cfg_wr_t              cfg,
	output logic [CNT_W-1:0]     capacity,
	// Slot memory.
	output logic                 ram_we,
	output logic [IDX_W-1:0]     ram_waddr,
	output logic [WORD_BITS-1:0] ram_wdata,
	output logic                 ram_re,
	output logic [IDX_W-1:0]     ram_raddr,
	input  logic [WORD_BITS-1:0] ram_rdata
);

	state_t state_q, state_nxt;

	logic [IDX_W-1:0]     head_q, tail_q, rd_idx_q, idx_s1;
	logic [CNT_W-1:0]     occ_q, cap_q, rd_cnt_q, pos_s1;
	logic                 valid_s1;
	cmd_t                 cmd_q;
	logic [WORD_BITS-1:0] key_q, repl_q;
	status_t              res_status_q;
	logic [WORD_BITS-1:0] res_data_q;
	logic [CNT_W-1:0]     res_pos_q;
	logic                 out_valid_q;
	logic [STATUS_BITS-1:0] out_status_q;
	logic [WORD_BITS-1:0] out_data_q;
	logic [POS_BITS-1:0]  out_pos_q;

	logic full, empty, match_s1, last_s1, issue, out_free, load;
	logic [CNT_W-1:0] cap_new;

	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nxt;
		nxt = CNT_W'(idx) + CNT_W'(1);
		return (nxt >= cap) ? '0 : IDX_W'(nxt);
	endfunction

	assign full     = (occ_q >= cap_q);
	assign empty    = (occ_q == '0);
	assign match_s1 = valid_s1 && (ram_rdata == key_q);
	assign last_s1  = valid_s1 && (pos_s1 == occ_q);
	assign issue    = (state_q == ST_SCAN) && (rd_cnt_q != occ_q);
	assign out_free = !out_valid_q || out_ready;
	assign load     = (state_q == ST_FIN) && out_free;

	// Out-of-range capacity values saturate to the storage limits.
	always_comb begin
		if (cfg.wdata == '0) begin
			cap_new = CNT_W'(1);
		end else if (cfg.wdata > APB_DATA'(DEPTH)) begin
			cap_new = CNT_W'(DEPTH);
		end else begin
			cap_new = CNT_W'(cfg.wdata);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_ENQ:  state_nxt = ST_FIN;
					CMD_DEQ:  state_nxt = empty ? ST_FIN : ST_DEQ;
					default:  state_nxt = empty ? ST_FIN : ST_SCAN;
				endcase
			end
			ST_DEQ: state_nxt = ST_FIN;
			ST_SCAN: begin
				if (match_s1 || last_s1) state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		ram_we    = ((state_q == ST_EXEC) && (cmd_q == CMD_ENQ) && !full) ||
			((state_q == ST_SCAN) && match_s1 && (cmd_q == CMD_REPL));
		ram_waddr = (state_q == ST_EXEC) ? tail_q : idx_s1;
		ram_wdata = (state_q == ST_EXEC) ? key_q : repl_q;
		ram_re    = ((state_q == ST_EXEC) && (cmd_q == CMD_DEQ) && !empty) || issue;
		ram_raddr = (state_q == ST_EXEC) ? head_q : rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			cap_q       <= CNT_W'(DEPTH);
			rd_idx_q    <= '0;
			rd_cnt_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg.we && empty) begin
				cap_q  <= cap_new;
				head_q <= '0;
				tail_q <= '0;
			end
			if ((state_q == ST_EXEC) && (cmd_q == CMD_ENQ) && !full) begin
				tail_q <= advance(tail_q, cap_q);
				occ_q  <= occ_q + CNT_W'(1);
			end
			if (state_q == ST_DEQ) begin
				head_q <= advance(head_q, cap_q);
				occ_q  <= occ_q - CNT_W'(1);
			end
			if (state_q == ST_EXEC) begin
				rd_idx_q <= head_q;
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_idx_q <= advance(rd_idx_q, cap_q);
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			valid_s1 <= issue;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd_t'(cmd);
			key_q  <= value;
			repl_q <= new_value;
		end
		if (issue) begin
			idx_s1 <= rd_idx_q;
			pos_s1 <= rd_cnt_q + CNT_W'(1);
		end
		unique case (state_q)
			ST_EXEC: begin
				res_status_q <= STAT_OK;
				res_data_q   <= '0;
				res_pos_q    <= '0;
				unique case (cmd_q)
					CMD_ENQ: if (full) res_status_q <= STAT_OVERFLOW;
					CMD_DEQ: if (empty) res_status_q <= STAT_UNDERFLOW;
					default: if (empty) res_status_q <= STAT_NOT_FOUND;
				endcase
			end
			ST_DEQ: res_data_q <= ram_rdata;
			ST_SCAN: begin
				if (match_s1) begin
					res_pos_q <= pos_s1;
				end else if (last_s1) begin
					res_status_q <= STAT_NOT_FOUND;
				end
			end
			default: ;
		endcase
		if (load) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_pos_q    <= POS_BITS'(res_pos_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data      = out_data_q;
	assign position  = out_pos_q;
	assign capacity  = cap_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the circular queue with search and replace.
//
// A clocked driver feeds command items from a backlog that the stimulus
// block fills, and a clocked monitor watches both handshakes. When a command
// item is accepted, the monitor runs it through a private model of the queue
// (slots, front and back pointers, occupancy and capacity) and appends the
// predicted result item to a list of awaited answers. Each result item that
// the block hands over is compared, field by field, with the oldest awaited
// answer.
//
// The capacity register is only written when nothing is in flight. The
// model applies the same rules as the block: the write is taken only while
// the queue is empty, resets both pointers, and saturates zero to one and
// anything above the storage depth to the depth.
module tb_top;
	import cqsr_pkg::*;

	localparam int WORD_W      = WORD_BITS_DEF;
	localparam int IDX_W       = $clog2(DEPTH_DEF);
	localparam int REG_COUNT   = 1;          // Registers in the map.
	localparam int REG_SPARE   = REG_COUNT;  // First index past the map.
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 165;
	localparam int CYCLE_LIMIT = 1000000;

	typedef logic signed [WORD_W-1:0] word_t;

	// One command item as it goes to the block.
	typedef struct {
		cmd_t  op;
		word_t word;
		word_t repl;
	} queue_cmd_t;

	// One result item as the block should return it.
	typedef struct {
		status_t             status;
		word_t               data;
		logic [POS_BITS-1:0] position;
	} queue_answer_t;

	// Clock, reset and every block input start at known values.
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [CMD_BITS-1:0]   cmd       = '0;
	word_t                 value     = '0;
	word_t                 new_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_BITS-1:0] status;
	word_t                 data;
	logic [POS_BITS-1:0]   position;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR-1:0]   paddr     = '0;
	logic [APB_DATA-1:0]   pwdata    = '0;
	logic [APB_DATA-1:0]   prdata;
	logic                  pready;

	circular_queue_search_replace DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.value     (value),
		.new_value (new_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data      (data),
		.position  (position),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Command items waiting to be driven, and predicted result items waiting
	// for the block to produce them.
	queue_cmd_t    cmd_backlog[$];
	queue_answer_t awaited_answers[$];

	// Words that were enqueued recently. Search and replace keys are mostly
	// drawn from here so that the scans actually find something.
	word_t recent_words[$];

	// Percentages of cycles in which the sender idles and the receiver
	// stalls. The stimulus block changes them from one phase to the next.
	int send_gap_pct   = 14;
	int recv_stall_pct = 45;

	int   mismatch_count = 0;
	int   cycle_count    = 0;
	logic item_taken     = 1'b0;

	// Private copy of the queue state. Unwritten slots hold zero here, but
	// the stimulus never makes the block read one.
	word_t               q_slots[DEPTH_DEF];
	logic [IDX_W-1:0]    q_head  = '0;
	logic [IDX_W-1:0]    q_tail  = '0;
	logic [POS_BITS-1:0] q_count = '0;
	logic [POS_BITS-1:0] q_cap   = POS_BITS'(DEPTH_DEF);

	initial begin
		foreach (q_slots[i])
			q_slots[i] = '0;
	end

	// Pointers wrap at the programmed capacity, not at the storage depth.
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
		logic [POS_BITS-1:0] nxt;
		nxt = POS_BITS'(idx) + 1'b1;
		return (nxt >= q_cap) ? '0 : nxt[IDX_W-1:0];
	endfunction

	// Walks the occupied slots from the front. The position is 1-based and
	// is zero when no slot holds the key.
	function automatic void find_first_match(input word_t key,
			output logic [POS_BITS-1:0] pos, output logic [IDX_W-1:0] where);
		logic [IDX_W-1:0] idx;
		idx   = q_head;
		pos   = '0;
		where = '0;
		for (int k = 0; k < q_count; k++) begin
			if (q_slots[idx] == key) begin
				pos   = POS_BITS'(k + 1);
				where = idx;
				return;
			end
			idx = next_slot(idx);
		end
	endfunction

	// Applies one command item to the model and returns what the block must
	// answer for it.
	function automatic queue_answer_t apply_queue_cmd(input cmd_t op, input word_t word,
			input word_t repl);
		queue_answer_t    ans;
		logic [IDX_W-1:0] where;
		ans.status   = STAT_OK;
		ans.data     = '0;
		ans.position = '0;
		case (op)
			CMD_ENQ: begin
				if (q_count >= q_cap) begin
					ans.status = STAT_OVERFLOW;
				end else begin
					q_slots[q_tail] = word;
					q_tail          = next_slot(q_tail);
					q_count         = q_count + 1'b1;
				end
			end
			CMD_DEQ: begin
				if (q_count == 0) begin
					ans.status = STAT_UNDERFLOW;
				end else begin
					ans.data = q_slots[q_head];
					q_head   = next_slot(q_head);
					q_count  = q_count - 1'b1;
				end
			end
			CMD_FIND: begin
				find_first_match(word, ans.position, where);
				if (ans.position == 0)
					ans.status = STAT_NOT_FOUND;
			end
			default: begin
				find_first_match(word, ans.position, where);
				if (ans.position == 0)
					ans.status = STAT_NOT_FOUND;
				else
					q_slots[where] = repl;
			end
		endcase
		return ans;
	endfunction

	// The capacity register only takes effect while the queue is empty.
	function automatic void apply_capacity_write(input logic [APB_DATA-1:0] wval);
		if (q_count != 0)
			return;
		if (wval == 0)
			q_cap = POS_BITS'(1);
		else if (wval > DEPTH_DEF)
			q_cap = POS_BITS'(DEPTH_DEF);
		else
			q_cap = wval[POS_BITS-1:0];
		q_head = '0;
		q_tail = '0;
	endfunction

	// Driver. It changes inputs at the falling edge. Once valid is raised it
	// holds the item until the monitor has seen it accepted; only then does
	// it either pick the next item from the backlog or leave valid low.
	always @(negedge clk) begin
		queue_cmd_t nxt;
		if (arst_n) begin
			if (!in_valid || item_taken) begin
				item_taken = 1'b0;
				if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					nxt = cmd_backlog.pop_front();
					in_valid  <= 1'b1;
					cmd       <= nxt.op;
					value     <= nxt.word;
					new_value <= nxt.repl;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor. Both handshakes are sampled at the rising edge. An accepted
	// command item is predicted right away, which is safe because the model
	// sees the items in the same order the block does and the register is
	// never written while anything is in flight.
	always @(posedge clk) begin
		queue_answer_t got;
		queue_answer_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				awaited_answers.push_back(apply_queue_cmd(cmd_t'(cmd), value, new_value));
				item_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				got.status   = status_t'(status);
				got.data     = data;
				got.position = position;
				if (awaited_answers.size() == 0) begin
					$error("result item with no answer awaited: status %0d data %0d position %0d",
						status, data, position);
					mismatch_count++;
				end else begin
					want = awaited_answers.pop_front();
					if (got.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d", want.status, status);
						mismatch_count++;
					end
					if (got.data !== want.data) begin
						$error("data mismatch: expected %0d, actual %0d", want.data, data);
						mismatch_count++;
					end
					if (got.position !== want.position) begin
						$error("position mismatch: expected %0d, actual %0d",
							want.position, position);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog. A hung block or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic push_item(input cmd_t op, input word_t word, input word_t repl);
		queue_cmd_t item;
		item.op   = op;
		item.word = word;
		item.repl = repl;
		cmd_backlog.push_back(item);
		if (op == CMD_ENQ) begin
			recent_words.push_back(word);
			if (recent_words.size() > 24)
				void'(recent_words.pop_front());
		end
	endtask

	// Returns once every item has been driven and accepted and every result
	// item has come back.
	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || in_valid || awaited_answers.size() != 0)
			@(posedge clk);
	endtask

	// One register write: a setup phase and then an access phase that ends
	// when pready is seen high at a rising edge.
	task automatic write_register(input int idx, input logic [APB_DATA-1:0] wval);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= APB_ADDR'(idx * 4);
		pwdata  <= wval;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_CAPACITY)
			apply_capacity_write(wval);
	endtask

	// A word for data or keys: corner values, repeats of recent words, or
	// fully random bits.
	function automatic word_t pick_word();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			case ($urandom_range(0, 4))
				0:       return '0;
				1:       return '1;
				2:       return {1'b0, {(WORD_W-1){1'b1}}};
				3:       return {1'b1, {(WORD_W-1){1'b0}}};
				default: return word_t'($urandom_range(1, 8));
			endcase
		end
		if (sel < 35 && recent_words.size() > 0)
			return recent_words[$urandom_range(0, recent_words.size() - 1)];
		return word_t'($urandom);
	endfunction

	// Random command items. The share of enqueues drifts every few dozen
	// items, so the queue swings between empty and full and the pointers
	// wrap at every capacity that gets programmed.
	task automatic push_random_items(input int n);
		int    enq_pct;
		int    pick;
		cmd_t  op;
		word_t key;
		word_t repl;
		enq_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				enq_pct = $urandom_range(15, 75);
			pick = $urandom_range(0, 99);
			if (pick < enq_pct) begin
				op = CMD_ENQ;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: op = CMD_DEQ;
					4, 5, 6:    op = CMD_FIND;
					default:    op = CMD_REPL;
				endcase
			end
			if ((op == CMD_FIND || op == CMD_REPL) && recent_words.size() > 0
					&& $urandom_range(0, 99) < 70)
				key = recent_words[$urandom_range(0, recent_words.size() - 1)];
			else
				key = pick_word();
			repl = ($urandom_range(0, 3) == 0) ? pick_word() : word_t'($urandom);
			push_item(op, key, repl);
		end
	endtask

	initial begin
		logic [APB_DATA-1:0] cap_word;
		word_t               w_max;
		word_t               w_min;
		w_max = {1'b0, {(WORD_W-1){1'b1}}};
		w_min = {1'b1, {(WORD_W-1){1'b0}}};

		// Reset is held from the start and released on a falling edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset capacity. An empty queue first: dequeue
		// underflows, and search and replace find nothing.
		push_item(CMD_DEQ,  '0, '0);
		push_item(CMD_FIND, '0, '0);
		push_item(CMD_REPL, '0, w_max);
		// Fill with the extreme words, one of them twice.
		push_item(CMD_ENQ, w_max, '0);
		push_item(CMD_ENQ, w_min, '0);
		push_item(CMD_ENQ, '0, '0);
		push_item(CMD_ENQ, '1, '0);
		push_item(CMD_ENQ, w_min, '0);
		// The first of two equal words is the one reported and replaced.
		push_item(CMD_FIND, w_min, '0);
		push_item(CMD_FIND, word_t'(32'h0001_2345), '0);
		push_item(CMD_REPL, '1, w_max);
		push_item(CMD_FIND, w_max, '0);
		push_item(CMD_REPL, w_min, '0);
		push_item(CMD_FIND, w_min, '0);
		// Drain it completely and dequeue once more.
		repeat (5)
			push_item(CMD_DEQ, '1, '1);
		push_item(CMD_DEQ, '0, '0);
		wait_drained();

		// A single slot: the second enqueue overflows.
		write_register(REG_CAPACITY, 1);
		push_item(CMD_ENQ,  word_t'(32'hA5A5_A5A5), '0);
		push_item(CMD_ENQ,  word_t'(32'h5A5A_5A5A), '0);
		push_item(CMD_REPL, word_t'(32'hA5A5_A5A5), word_t'(32'h5A5A_5A5A));
		push_item(CMD_FIND, word_t'(32'h5A5A_5A5A), '0);
		wait_drained();

		// A capacity write while the queue holds a word must be ignored, and
		// so must a write past the end of the register map.
		write_register(REG_CAPACITY, 3);
		write_register(REG_SPARE, 7);
		push_item(CMD_ENQ, '0, '0);
		push_item(CMD_DEQ, '0, '0);
		push_item(CMD_DEQ, '0, '0);
		wait_drained();

		// Random phases. Each third of the run has its own idling pattern:
		// a mostly busy sender facing a slow receiver, then the reverse, then
		// no idling at all. Most phases empty the queue first so that the
		// new capacity takes hold; the others do not, so words left behind make
		// the write a no-op and carry the old contents across.
		for (int p = 0; p < PHASES; p++) begin
			case (p / 4)
				0: begin
					send_gap_pct   = 14;
					recv_stall_pct = 45;
				end
				1: begin
					send_gap_pct   = 45;
					recv_stall_pct = 14;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
			endcase
			if (p % 3 != 2) begin
				repeat (int'(q_count))
					push_item(CMD_DEQ, word_t'($urandom), word_t'($urandom));
				wait_drained();
			end
			case (p)
				0:       cap_word = DEPTH_DEF;
				1:       cap_word = 1;
				2:       cap_word = 0;
				3:       cap_word = '1;
				4:       cap_word = DEPTH_DEF + 1;
				5:       cap_word = 2;
				default: cap_word = $urandom_range(1, DEPTH_DEF);
			endcase
			write_register(REG_CAPACITY, cap_word);
			if (p == 7)
				write_register(REG_SPARE, $urandom);
			if (p == 6) begin
				// The sender holds back here until everything has come back.
				push_random_items(PHASE_ITEMS / 2);
				wait_drained();
				push_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				push_random_items(PHASE_ITEMS);
			end
			wait_drained();
		end

		// Let any late, unexpected result item show up before the verdict.
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
